### rtl/mcst_pkg.sv
// Shared types and constants for the multi-channel soft timer.
// Used by the channel interfaces, the countdown unit, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mcst_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 8;
  localparam int DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK       = 3'd0,
    FN_START_ONCE = 3'd1,
    FN_START_AUTO = 3'd2,
    FN_STOP       = 3'd3,
    FN_CHECK      = 3'd4,
    FN_ELAPSED    = 3'd5
  } func_t;

  // Operands handed to the shared countdown unit.
  typedef struct packed {
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] reload_value;
    logic              auto_reload;
  } cdu_in_t;

  // Countdown unit answer: busy means the count was nonzero and must be written back.
  typedef struct packed {
    logic [DATA_W-1:0] remaining;
    logic              busy;
    logic              fire;
  } cdu_out_t;

endpackage

`default_nettype wire

### rtl/mcst_if.sv
// Valid/ready channel interfaces for the multi-channel soft timer.
// Depends on mcst_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mcst_in_if;
  logic                        valid;
  logic                        ready;
  logic [mcst_pkg::FUNC_W-1:0] func;
  logic [mcst_pkg::ID_W-1:0]   timer_id;
  logic [mcst_pkg::DATA_W-1:0] period;
  logic [mcst_pkg::DATA_W-1:0] prev_tick;

  modport source (output valid, func, timer_id, period, prev_tick, input ready);
  modport sink   (input valid, func, timer_id, period, prev_tick, output ready);
endinterface

interface mcst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        expired;
  logic [mcst_pkg::DATA_W-1:0] elapsed_ticks;
  logic [mcst_pkg::DATA_W-1:0] tick_now;

  modport source (output valid, expired, elapsed_ticks, tick_now, input ready);
  modport sink   (input valid, expired, elapsed_ticks, tick_now, output ready);
endinterface

`default_nettype wire

### rtl/mcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/mcst_cdu.sv
// Shared countdown unit: one decrement, zero test and reload select per cycle.
// Depends on mcst_pkg for the operand structs.
`timescale 1ns / 1ps
`default_nettype none

module mcst_cdu (
  input  wire mcst_pkg::cdu_in_t  op,
  output mcst_pkg::cdu_out_t      res
);

  logic [mcst_pkg::DATA_W-1:0] dec;

  always_comb begin
    dec       = op.remaining - mcst_pkg::DATA_W'(1);
    res.busy  = (op.remaining != '0);
    res.fire  = res.busy && (dec == '0);
    // reload on expiry for auto-reload timers, else take the decremented count (zero for an expired one-shot timer)
    if (res.fire && op.auto_reload) begin
      res.remaining = op.reload_value;
    end else begin
      res.remaining = dec;
    end
  end

endmodule

`default_nettype wire

### rtl/multi_channel_soft_timer.sv
// Multi-channel soft timer: a bank of TIMERS countdown timers behind one valid/ready input
// channel and one result channel. Start, stop, check and elapsed items finish in the cycle
// they are accepted, so they can follow each other every cycle as long as the result is taken.
// A tick item holds off other items while the timers are swept: their counts and reload values
// sit in one RAM with a single read port, and one shared countdown unit visits one timer per
// cycle behind the registered read. The result of every item, including a tick, is loaded
// into the output register when the item is accepted. All timers read as cleared after reset
// through per-timer valid bits; no clearing pass is needed.
// Depends on mcst_pkg, mcst_if, mcst_ram and mcst_cdu.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_soft_timer #(
  parameter int TIMERS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  mcst_in_if.sink      in_ch,
  mcst_out_if.source   out_ch
);

  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam int DW = mcst_pkg::DATA_W;
  localparam logic [CW-1:0] SCAN_END = CW'(TIMERS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        scan_idx_r, scan_idx_nxt;
  logic                 proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]        proc_idx_r, proc_idx_nxt;
  logic [DW-1:0]        tick_r, tick_nxt;
  logic [TIMERS-1:0]    valid_r, valid_nxt;
  logic [TIMERS-1:0]    flag_r, flag_nxt;
  logic [TIMERS-1:0]    auto_r, auto_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_expired_r, out_expired_nxt;
  logic [DW-1:0]        out_elapsed_r, out_elapsed_nxt;
  logic [DW-1:0]        out_tick_r, out_tick_nxt;

  logic                 accept;
  logic                 issue;
  logic                 slot_ok;
  logic [AW-1:0]        slot;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*DW-1:0]      ram_wdata;
  logic [2*DW-1:0]      ram_rdata;

  mcst_pkg::cdu_in_t    cdu_op;
  mcst_pkg::cdu_out_t   cdu_res;

  mcst_ram #(
    .WIDTH (2 * DW),
    .DEPTH (TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  mcst_cdu u_cdu (
    .op  (cdu_op),
    .res (cdu_res)
  );

  assign in_ch.ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept         = in_ch.valid && in_ch.ready;
  assign slot_ok        = (in_ch.timer_id < mcst_pkg::ID_W'(TIMERS));
  assign slot           = in_ch.timer_id[AW-1:0];
  assign issue          = (state_r == ST_SCAN) && (scan_idx_r != SCAN_END);

  // an entry never written since reset or stop reads as a cleared timer
  always_comb begin
    cdu_op.remaining    = valid_r[proc_idx_r] ? ram_rdata[DW-1:0] : '0;
    cdu_op.reload_value = valid_r[proc_idx_r] ? ram_rdata[2*DW-1:DW] : '0;
    cdu_op.auto_reload  = auto_r[proc_idx_r];
  end

  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    proc_vld_nxt    = issue;
    proc_idx_nxt    = scan_idx_r[AW-1:0];
    tick_nxt        = tick_r;
    valid_nxt       = valid_r;
    flag_nxt        = flag_r;
    auto_nxt        = auto_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_expired_nxt = out_expired_r;
    out_elapsed_nxt = out_elapsed_r;
    out_tick_nxt    = out_tick_r;
    ram_we          = 1'b0;
    ram_waddr       = proc_idx_r;
    ram_wdata       = {cdu_op.reload_value, cdu_res.remaining};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_expired_nxt = 1'b0;
          out_elapsed_nxt = '0;
          out_tick_nxt    = tick_r;
          unique case (mcst_pkg::func_t'(in_ch.func))
            mcst_pkg::FN_TICK: begin
              tick_nxt     = tick_r + DW'(1);
              out_tick_nxt = tick_r + DW'(1);
              scan_idx_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            mcst_pkg::FN_START_ONCE, mcst_pkg::FN_START_AUTO: begin
              if (slot_ok) begin
                ram_we          = 1'b1;
                ram_waddr       = slot;
                ram_wdata       = {in_ch.period, in_ch.period};
                valid_nxt[slot] = 1'b1;
                flag_nxt[slot]  = 1'b0;
                auto_nxt[slot]  = (in_ch.func == mcst_pkg::FN_START_AUTO);
              end
            end
            mcst_pkg::FN_STOP: begin
              if (slot_ok) begin
                valid_nxt[slot] = 1'b0;
                flag_nxt[slot]  = 1'b0;
                auto_nxt[slot]  = 1'b0;
              end
            end
            mcst_pkg::FN_CHECK: begin
              if (slot_ok) begin
                out_expired_nxt = flag_r[slot];
                flag_nxt[slot]  = 1'b0;
              end
            end
            mcst_pkg::FN_ELAPSED: begin
              out_elapsed_nxt = tick_r - in_ch.prev_tick;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
        // write back the timer whose read data arrived this cycle
        if (proc_vld_r && cdu_res.busy) begin
          ram_we = 1'b1;
          if (cdu_res.fire) begin
            flag_nxt[proc_idx_r] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      proc_vld_r  <= 1'b0;
      tick_r      <= '0;
      valid_r     <= '0;
      flag_r      <= '0;
      auto_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      proc_vld_r  <= proc_vld_nxt;
      tick_r      <= tick_nxt;
      valid_r     <= valid_nxt;
      flag_r      <= flag_nxt;
      auto_r      <= auto_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r    <= proc_idx_nxt;
    out_expired_r <= out_expired_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_tick_r    <= out_tick_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.expired       = out_expired_r;
  assign out_ch.elapsed_ticks = out_elapsed_r;
  assign out_ch.tick_now      = out_tick_r;

endmodule

`default_nettype wire

### rtl/mcst_checker.sv
// Port-level checker for the multi-channel soft timer, bound to the top level.
// Depends on mcst_pkg for the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module mcst_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [mcst_pkg::FUNC_W-1:0] in_func,
  input wire logic [mcst_pkg::DATA_W-1:0] in_prev_tick,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [mcst_pkg::DATA_W-1:0] out_elapsed_ticks,
  input wire logic [mcst_pkg::DATA_W-1:0] out_tick_now
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tick_now))
    else $error("tick_now changed while stalled");

  // elapsed equals the reported tick counter minus the given last tick
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == mcst_pkg::FN_ELAPSED |=>
      out_valid && (out_elapsed_ticks == out_tick_now - $past(in_prev_tick)))
    else $error("elapsed result does not match tick counter");

  // a tick holds off the next item while the timers are swept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == mcst_pkg::FN_TICK |=> !in_ready)
    else $error("item accepted during timer sweep");

endmodule

bind multi_channel_soft_timer mcst_checker u_mcst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_func           (in_ch.func),
  .in_prev_tick      (in_ch.prev_tick),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_elapsed_ticks (out_ch.elapsed_ticks),
  .out_tick_now      (out_ch.tick_now)
);

`default_nettype wire
